// ===== hw/rtl/ctlp_pkg.sv =====
package ctlp_pkg;

    localparam logic [3:0] HOUR_DIGITS = 4'd4;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SYNTAX = 3'd1;
    localparam logic [2:0] ST_RANGE  = 3'd2;
    localparam logic [2:0] ST_HOURS  = 3'd3;
    localparam logic [2:0] ST_ORDER  = 3'd4;

    localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
    localparam logic [15:0] MS_PER_MIN  = 16'd60000;
    localparam logic [9:0]  MS_PER_SEC  = 10'd1000;

    typedef struct packed {
        logic [2:0]  err;
        logic        settings;
        logic [13:0] st_h;
        logic [6:0]  st_m;
        logic [6:0]  st_s;
        logic [9:0]  st_ms;
        logic [13:0] en_h;
        logic [6:0]  en_m;
        logic [6:0]  en_s;
        logic [9:0]  en_ms;
    } line_rec_t;

endpackage

// ===== hw/rtl/cue_timing_line_parser.sv =====
// Cue timing line parser: reads a subtitle cue timing line one byte per beat and
// reports its start and end times in milliseconds with a status code.
// The input channel (in_valid, in_ready) carries char_byte and line_end; a line
// ends at LF, at CR, or after the byte marked by line_end.
// The output channel (out_valid, out_ready) carries start_ms, end_ms, status and
// settings_present, one beat per line that holds anything but blanks.
// Throughput is one input beat per cycle while in_ready is high.
// The record of a line's last beat loads into the field register at the edge
// that accepts that beat, then the result moves through a product stage and
// a sum-and-compare stage to the output.
// When the receiver stalls, the three result stages fill in turn and in_ready
// falls only once all of them hold a result; bytes keep flowing until then.
// Reset clears the parser to the start of a line and empties all result stages.
module cue_timing_line_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_byte,
    input  logic        line_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [35:0] start_ms,
    output logic [35:0] end_ms,
    output logic [2:0]  status,
    output logic        settings_present
);
    import ctlp_pkg::*;

    logic      accept;
    logic      emit;
    line_rec_t rec;

    assign accept = in_valid && in_ready;

    ctlp_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_byte (char_byte),
        .line_end  (line_end),
        .emit      (emit),
        .rec       (rec)
    );

    ctlp_time u_time (
        .clk              (clk),
        .rst_n            (rst_n),
        .rec_valid        (accept && emit),
        .rec              (rec),
        .rec_ready        (in_ready),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .start_ms         (start_ms),
        .end_ms           (end_ms),
        .status           (status),
        .settings_present (settings_present)
    );

endmodule

// ===== hw/rtl/ctlp_scan.sv =====
module ctlp_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          char_byte,
    input  logic                line_end,
    output logic                emit,
    output ctlp_pkg::line_rec_t rec
);
    import ctlp_pkg::*;

    localparam logic [4:0] P_LEAD   = 5'd0;
    localparam logic [4:0] P_START  = 5'd1;
    localparam logic [4:0] P_GAP1   = 5'd8;
    localparam logic [4:0] P_ARROW1 = 5'd9;
    localparam logic [4:0] P_ARROW2 = 5'd10;
    localparam logic [4:0] P_ARROW3 = 5'd11;
    localparam logic [4:0] P_GAP2   = 5'd12;
    localparam logic [4:0] P_END    = 5'd13;
    localparam logic [4:0] P_TAIL   = 5'd20;

    localparam logic [4:0] SUB_A  = 5'd0;
    localparam logic [4:0] SUB_B0 = 5'd1;
    localparam logic [4:0] SUB_B  = 5'd2;
    localparam logic [4:0] SUB_C0 = 5'd3;
    localparam logic [4:0] SUB_C  = 5'd4;
    localparam logic [4:0] SUB_M0 = 5'd5;
    localparam logic [4:0] SUB_M  = 5'd6;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;

    function automatic logic [2:0] finish_check(input logic [3:0] cnt, input logic [6:0] f2,
                                                input logic [6:0] f3, input logic hf);
        logic [2:0] r;
        r = ST_OK;
        if (cnt != 4'd3) begin
            r = ST_SYNTAX;
        end
        else if (f2 > 7'd59 || (hf && f3 > 7'd59)) begin
            r = ST_RANGE;
        end
        return r;
    endfunction

    logic [4:0]  phase_reg, phase_next, ph_f;
    logic [13:0] dval_reg, dval_next, dv_f;
    logic [3:0]  dcnt_reg, dcnt_next, dc_f;
    logic [13:0] f1_reg, f1_next, f1_f;
    logic [6:0]  f2_reg, f2_next, f2_f;
    logic [6:0]  f3_reg, f3_next, f3_f;
    logic        hform_reg, hform_next, hf_f;
    logic [13:0] sth_reg, sth_next, sh_f;
    logic [6:0]  stm_reg, stm_next, sm_f;
    logic [6:0]  sts_reg, sts_next, ss_f;
    logic [9:0]  stms_reg, stms_next, sms_f;
    logic [2:0]  err_reg, err_next, err_f;
    logic        set_reg, set_next, set_f;

    logic        is_blank, is_digit, is_alpha, term, eol, in_ts1, in_ts2, hf_tmp, clear;
    logic [4:0]  base, sub;
    logic [3:0]  digit;
    logic [17:0] dv_mul;
    logic [13:0] dv_add;
    logic [3:0]  dc_add;
    logic [2:0]  fin, line_err;

    always_comb
    begin
        is_blank = (char_byte == CH_SP) || (char_byte == CH_TAB);
        is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
        is_alpha = (char_byte >= 8'h41 && char_byte <= 8'h5A) ||
                   (char_byte >= 8'h61 && char_byte <= 8'h7A);
        term     = (char_byte == CH_LF) || (char_byte == CH_CR);
        digit    = char_byte[3:0];
        dv_mul   = 18'({dval_reg, 3'b000}) + 18'({dval_reg, 1'b0}) + 18'(digit);
        dv_add   = (dv_mul > 18'd16383) ? 14'd16383 : dv_mul[13:0];
        dc_add   = (dcnt_reg == 4'd15) ? 4'd15 : 4'(dcnt_reg + 4'd1);
        in_ts1   = (phase_reg >= P_START) && (phase_reg < P_GAP1);
        in_ts2   = (phase_reg >= P_END) && (phase_reg < P_TAIL);
        base     = in_ts2 ? P_END : P_START;
        sub      = 5'(phase_reg - base);
        fin      = finish_check(dcnt_reg, f2_reg, f3_reg, hform_reg);
        hf_tmp   = hform_reg || (dcnt_reg != 4'd2) || (dval_reg > 14'd59);

        ph_f  = phase_reg;
        dv_f  = dval_reg;
        dc_f  = dcnt_reg;
        f1_f  = f1_reg;
        f2_f  = f2_reg;
        f3_f  = f3_reg;
        hf_f  = hform_reg;
        sh_f  = sth_reg;
        sm_f  = stm_reg;
        ss_f  = sts_reg;
        sms_f = stms_reg;
        err_f = err_reg;
        set_f = set_reg;

        if (!term && err_reg == ST_OK)
        begin
            if (in_ts1 || in_ts2)
            begin
                case (sub)
                    SUB_A:
                    begin
                        if (is_digit)
                        begin
                            dv_f = dv_add;
                            dc_f = dc_add;
                        end
                        else if (char_byte != CH_COLON)
                        begin
                            err_f = ST_SYNTAX;
                        end
                        else
                        begin
                            f1_f = dval_reg;
                            hf_f = hf_tmp;
                            if (hf_tmp && dcnt_reg > HOUR_DIGITS)
                            begin
                                err_f = ST_HOURS;
                            end
                            else
                            begin
                                ph_f = 5'(base + SUB_B0);
                            end
                        end
                    end
                    SUB_B0, SUB_C0, SUB_M0:
                    begin
                        if (!is_digit)
                        begin
                            err_f = ST_SYNTAX;
                        end
                        else
                        begin
                            dv_f = 14'(digit);
                            dc_f = 4'd1;
                            ph_f = 5'(phase_reg + 5'd1);
                        end
                    end
                    SUB_B:
                    begin
                        if (is_digit)
                        begin
                            dv_f = dv_add;
                            dc_f = dc_add;
                        end
                        else if (dcnt_reg != 4'd2)
                        begin
                            err_f = ST_SYNTAX;
                        end
                        else
                        begin
                            f2_f = dval_reg[6:0];
                            if (char_byte == CH_COLON)
                            begin
                                hf_f = 1'b1;
                                ph_f = 5'(base + SUB_C0);
                            end
                            else if (char_byte == CH_DOT && !hform_reg)
                            begin
                                ph_f = 5'(base + SUB_M0);
                            end
                            else
                            begin
                                err_f = ST_SYNTAX;
                            end
                        end
                    end
                    SUB_C:
                    begin
                        if (is_digit)
                        begin
                            dv_f = dv_add;
                            dc_f = dc_add;
                        end
                        else if (dcnt_reg != 4'd2 || char_byte != CH_DOT)
                        begin
                            err_f = ST_SYNTAX;
                        end
                        else
                        begin
                            f3_f = dval_reg[6:0];
                            ph_f = 5'(base + SUB_M0);
                        end
                    end
                    default:
                    begin
                        if (is_digit)
                        begin
                            dv_f = dv_add;
                            dc_f = dc_add;
                        end
                        else if (fin != ST_OK)
                        begin
                            err_f = fin;
                        end
                        else if (!in_ts2)
                        begin
                            sh_f  = hform_reg ? f1_reg : 14'd0;
                            sm_f  = hform_reg ? f2_reg : f1_reg[6:0];
                            ss_f  = hform_reg ? f3_reg : f2_reg;
                            sms_f = dval_reg[9:0];
                            if (is_blank)
                            begin
                                ph_f = P_GAP1;
                            end
                            else
                            begin
                                err_f = ST_SYNTAX;
                            end
                        end
                        else
                        begin
                            ph_f = P_TAIL;
                            if (is_alpha)
                            begin
                                set_f = 1'b1;
                            end
                        end
                    end
                endcase
            end
            else
            begin
                case (phase_reg)
                    P_LEAD, P_GAP2:
                    begin
                        if (is_digit)
                        begin
                            hf_f = 1'b0;
                            dv_f = 14'(digit);
                            dc_f = 4'd1;
                            ph_f = (phase_reg == P_LEAD) ? P_START : P_END;
                        end
                        else if (!is_blank)
                        begin
                            err_f = ST_SYNTAX;
                        end
                    end
                    P_GAP1:
                    begin
                        if (char_byte == CH_DASH)
                        begin
                            ph_f = P_ARROW1;
                        end
                        else if (!is_blank)
                        begin
                            err_f = ST_SYNTAX;
                        end
                    end
                    P_ARROW1:
                    begin
                        if (char_byte == CH_DASH)
                        begin
                            ph_f = P_ARROW2;
                        end
                        else
                        begin
                            err_f = ST_SYNTAX;
                        end
                    end
                    P_ARROW2:
                    begin
                        if (char_byte == CH_GT)
                        begin
                            ph_f = P_ARROW3;
                        end
                        else
                        begin
                            err_f = ST_SYNTAX;
                        end
                    end
                    P_ARROW3:
                    begin
                        if (is_blank)
                        begin
                            ph_f = P_GAP2;
                        end
                        else
                        begin
                            err_f = ST_SYNTAX;
                        end
                    end
                    P_TAIL:
                    begin
                        if (is_alpha)
                        begin
                            set_f = 1'b1;
                        end
                    end
                    default:
                    begin
                        err_f = ST_SYNTAX;
                    end
                endcase
            end
        end

        eol      = term || line_end;
        clear    = eol;
        emit     = 1'b0;
        line_err = err_f;
        if (eol && !(err_f == ST_OK && ph_f == P_LEAD))
        begin
            emit = 1'b1;
            if (err_f == ST_OK)
            begin
                if (ph_f == 5'(P_END + SUB_M))
                begin
                    line_err = finish_check(dc_f, f2_f, f3_f, hf_f);
                end
                else if (ph_f != P_TAIL)
                begin
                    line_err = ST_SYNTAX;
                end
            end
        end

        rec.err      = line_err;
        rec.settings = set_f;
        rec.st_h     = sh_f;
        rec.st_m     = sm_f;
        rec.st_s     = ss_f;
        rec.st_ms    = sms_f;
        rec.en_h     = hf_f ? f1_f : 14'd0;
        rec.en_m     = hf_f ? f2_f : f1_f[6:0];
        rec.en_s     = hf_f ? f3_f : f2_f;
        rec.en_ms    = dv_f[9:0];

        phase_next = clear ? P_LEAD : ph_f;
        dval_next  = clear ? 14'd0 : dv_f;
        dcnt_next  = clear ? 4'd0 : dc_f;
        f1_next    = clear ? 14'd0 : f1_f;
        f2_next    = clear ? 7'd0 : f2_f;
        f3_next    = clear ? 7'd0 : f3_f;
        hform_next = clear ? 1'b0 : hf_f;
        sth_next   = clear ? 14'd0 : sh_f;
        stm_next   = clear ? 7'd0 : sm_f;
        sts_next   = clear ? 7'd0 : ss_f;
        stms_next  = clear ? 10'd0 : sms_f;
        err_next   = clear ? ST_OK : err_f;
        set_next   = clear ? 1'b0 : set_f;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_LEAD;
            dval_reg  <= 14'd0;
            dcnt_reg  <= 4'd0;
            f1_reg    <= 14'd0;
            f2_reg    <= 7'd0;
            f3_reg    <= 7'd0;
            hform_reg <= 1'b0;
            sth_reg   <= 14'd0;
            stm_reg   <= 7'd0;
            sts_reg   <= 7'd0;
            stms_reg  <= 10'd0;
            err_reg   <= ST_OK;
            set_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            dval_reg  <= dval_next;
            dcnt_reg  <= dcnt_next;
            f1_reg    <= f1_next;
            f2_reg    <= f2_next;
            f3_reg    <= f3_next;
            hform_reg <= hform_next;
            sth_reg   <= sth_next;
            stm_reg   <= stm_next;
            sts_reg   <= sts_next;
            stms_reg  <= stms_next;
            err_reg   <= err_next;
            set_reg   <= set_next;
        end
    end

endmodule

// ===== hw/rtl/ctlp_time.sv =====
module ctlp_time (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rec_valid,
    input  ctlp_pkg::line_rec_t rec,
    output logic                rec_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [35:0]         start_ms,
    output logic [35:0]         end_ms,
    output logic [2:0]          status,
    output logic                settings_present
);
    import ctlp_pkg::*;

    typedef struct packed {
        logic [2:0]  err;
        logic        settings;
        logic [35:0] st_hp;
        logic [22:0] st_mp;
        logic [16:0] st_sp;
        logic [9:0]  st_ms;
        logic [35:0] en_hp;
        logic [22:0] en_mp;
        logic [16:0] en_sp;
        logic [9:0]  en_ms;
    } prod_rec_t;

    line_rec_t   s1_reg;
    prod_rec_t   s2_reg, s2_next;
    logic        v1_reg, v2_reg, v3_reg;
    logic        rdy1, rdy2, rdy3;
    logic [35:0] st_sum, en_sum;
    logic [35:0] start_reg, start_next, end_reg, end_next;
    logic [2:0]  status_reg, status_next;
    logic        set_reg, set_next;

    assign rdy3      = !v3_reg || out_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign rec_ready = rdy1;

    always_comb
    begin
        s2_next.err      = s1_reg.err;
        s2_next.settings = s1_reg.settings;
        s2_next.st_hp    = 36'(s1_reg.st_h) * MS_PER_HOUR;
        s2_next.st_mp    = 23'(s1_reg.st_m) * MS_PER_MIN;
        s2_next.st_sp    = 17'(s1_reg.st_s) * MS_PER_SEC;
        s2_next.st_ms    = s1_reg.st_ms;
        s2_next.en_hp    = 36'(s1_reg.en_h) * MS_PER_HOUR;
        s2_next.en_mp    = 23'(s1_reg.en_m) * MS_PER_MIN;
        s2_next.en_sp    = 17'(s1_reg.en_s) * MS_PER_SEC;
        s2_next.en_ms    = s1_reg.en_ms;

        st_sum = s2_reg.st_hp + 36'(s2_reg.st_mp) + 36'(s2_reg.st_sp) + 36'(s2_reg.st_ms);
        en_sum = s2_reg.en_hp + 36'(s2_reg.en_mp) + 36'(s2_reg.en_sp) + 36'(s2_reg.en_ms);

        if (s2_reg.err != ST_OK)
        begin
            start_next  = 36'd0;
            end_next    = 36'd0;
            set_next    = 1'b0;
            status_next = s2_reg.err;
        end
        else
        begin
            start_next  = st_sum;
            end_next    = en_sum;
            set_next    = s2_reg.settings;
            status_next = (st_sum > en_sum) ? ST_ORDER : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= rec_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && rec_valid)
        begin
            s1_reg <= rec;
        end
        if (rdy2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (rdy3 && v2_reg)
        begin
            start_reg  <= start_next;
            end_reg    <= end_next;
            status_reg <= status_next;
            set_reg    <= set_next;
        end
    end

    assign out_valid        = v3_reg;
    assign start_ms         = start_reg;
    assign end_ms           = end_reg;
    assign status           = status_reg;
    assign settings_present = set_reg;

endmodule

// ===== dv/cue_timing_line_parser_tb.sv =====
module cue_timing_line_parser_tb;
    import ctlp_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_CHARS = 1700;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_GT    = 8'h3E;

    localparam logic [4:0] P_LEAD   = 5'd0;
    localparam logic [4:0] P_START  = 5'd1;
    localparam logic [4:0] P_GAP1   = 5'd8;
    localparam logic [4:0] P_ARROW1 = 5'd9;
    localparam logic [4:0] P_ARROW2 = 5'd10;
    localparam logic [4:0] P_ARROW3 = 5'd11;
    localparam logic [4:0] P_GAP2   = 5'd12;
    localparam logic [4:0] P_END    = 5'd13;
    localparam logic [4:0] P_TAIL   = 5'd20;

    localparam logic [4:0] S_A  = 5'd0;
    localparam logic [4:0] S_B0 = 5'd1;
    localparam logic [4:0] S_B  = 5'd2;
    localparam logic [4:0] S_C0 = 5'd3;
    localparam logic [4:0] S_C  = 5'd4;
    localparam logic [4:0] S_M0 = 5'd5;
    localparam logic [4:0] S_M  = 5'd6;

    typedef enum int {TERM_LF, TERM_CRLF, TERM_CR, TERM_FLAG} term_e;

    typedef logic [7:0] chars_t[$];

    typedef struct packed {
        logic [35:0] start_t;
        logic [35:0] stop_t;
        logic [2:0]  code;
        logic        letters;
    } cue_times_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  char_byte;
    logic        line_end;
    logic        out_valid;
    logic        out_ready;
    logic [35:0] start_ms;
    logic [35:0] end_ms;
    logic [2:0]  status;
    logic        settings_present;

    cue_times_t expected_times[$];
    int         mismatches = 0;
    int         sent_chars = 0;
    bit         send_idle = 0;
    bit         take_idle = 0;

    logic [4:0]  ph;
    logic [13:0] run_val;
    logic [3:0]  run_len;
    logic [13:0] fld_a;
    logic [6:0]  fld_b;
    logic [6:0]  fld_c;
    logic        hrs;
    logic [35:0] start_acc;
    logic [2:0]  err;
    logic        letters;

    cue_timing_line_parser DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .char_byte        (char_byte),
        .line_end         (line_end),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .start_ms         (start_ms),
        .end_ms           (end_ms),
        .status           (status),
        .settings_present (settings_present)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic void flag_error(logic [2:0] code);
        if (err == ST_OK)
            err = code;
    endfunction

    function automatic void clear_parser();
        ph = P_LEAD;
        run_val = '0;
        run_len = '0;
        fld_a = '0;
        fld_b = '0;
        fld_c = '0;
        hrs = 1'b0;
        start_acc = '0;
        err = ST_OK;
        letters = 1'b0;
    endfunction

    function automatic void first_digit(logic [7:0] c);
        run_val = 14'(c - CH_ZERO);
        run_len = 4'd1;
    endfunction

    function automatic void next_digit(logic [7:0] c);
        int v;
        v = int'(run_val) * 10 + int'(c - CH_ZERO);
        run_val = (v > 16383) ? 14'd16383 : 14'(v);
        if (run_len < 4'd15)
            run_len = run_len + 4'd1;
    endfunction

    function automatic logic [35:0] stamp_ms();
        longint unsigned h;
        longint unsigned m;
        longint unsigned s;
        longint unsigned total;
        h = hrs ? longint'(fld_a) : 0;
        m = hrs ? longint'(fld_b) : longint'(fld_a);
        s = hrs ? longint'(fld_c) : longint'(fld_b);
        total = h * MS_PER_HOUR + m * MS_PER_MIN + s * MS_PER_SEC + longint'(run_val);
        return total[35:0];
    endfunction

    function automatic bit close_ms();
        if (run_len != 4'd3)
        begin
            flag_error(ST_SYNTAX);
            return 1'b0;
        end
        if (fld_b > 7'd59 || (hrs && fld_c > 7'd59))
        begin
            flag_error(ST_RANGE);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void stamp_char(logic [4:0] base, logic [7:0] c);
        logic [4:0] sub;
        bit         dg;
        sub = ph - base;
        dg = is_digit(c);
        case (sub)
            S_A:
                if (dg)
                    next_digit(c);
                else if (c != CH_COLON)
                    flag_error(ST_SYNTAX);
                else
                begin
                    fld_a = run_val;
                    if (run_len != 4'd2 || run_val > 14'd59)
                        hrs = 1'b1;
                    if (hrs && run_len > HOUR_DIGITS)
                        flag_error(ST_HOURS);
                    else
                        ph = base + S_B0;
                end
            S_B0, S_C0, S_M0:
                if (!dg)
                    flag_error(ST_SYNTAX);
                else
                begin
                    first_digit(c);
                    ph = base + sub + 5'd1;
                end
            S_B:
                if (dg)
                    next_digit(c);
                else if (run_len != 4'd2)
                    flag_error(ST_SYNTAX);
                else
                begin
                    fld_b = run_val[6:0];
                    if (c == CH_COLON)
                    begin
                        hrs = 1'b1;
                        ph = base + S_C0;
                    end
                    else if (c == CH_DOT && !hrs)
                        ph = base + S_M0;
                    else
                        flag_error(ST_SYNTAX);
                end
            S_C:
                if (dg)
                    next_digit(c);
                else if (run_len != 4'd2 || c != CH_DOT)
                    flag_error(ST_SYNTAX);
                else
                begin
                    fld_c = run_val[6:0];
                    ph = base + S_M0;
                end
            default:
                if (dg)
                    next_digit(c);
                else if (close_ms())
                begin
                    if (base == P_START)
                    begin
                        start_acc = stamp_ms();
                        if (is_blank(c))
                            ph = P_GAP1;
                        else
                            flag_error(ST_SYNTAX);
                    end
                    else
                    begin
                        ph = P_TAIL;
                        if (is_alpha(c))
                            letters = 1'b1;
                    end
                end
        endcase
    endfunction

    function automatic void feed_char(logic [7:0] c);
        if (err != ST_OK)
            return;
        if (ph >= P_START && ph < P_GAP1)
            stamp_char(P_START, c);
        else if (ph >= P_END && ph < P_TAIL)
            stamp_char(P_END, c);
        else
            case (ph)
                P_LEAD, P_GAP2:
                    if (!is_blank(c))
                    begin
                        if (is_digit(c))
                        begin
                            hrs = 1'b0;
                            first_digit(c);
                            ph = (ph == P_LEAD) ? P_START : P_END;
                        end
                        else
                            flag_error(ST_SYNTAX);
                    end
                P_GAP1:
                    if (!is_blank(c))
                    begin
                        if (c == CH_DASH)
                            ph = P_ARROW1;
                        else
                            flag_error(ST_SYNTAX);
                    end
                P_ARROW1:
                    if (c == CH_DASH)
                        ph = P_ARROW2;
                    else
                        flag_error(ST_SYNTAX);
                P_ARROW2:
                    if (c == CH_GT)
                        ph = P_ARROW3;
                    else
                        flag_error(ST_SYNTAX);
                P_ARROW3:
                    if (is_blank(c))
                        ph = P_GAP2;
                    else
                        flag_error(ST_SYNTAX);
                P_TAIL:
                    if (is_alpha(c))
                        letters = 1'b1;
                default:
                    flag_error(ST_SYNTAX);
            endcase
    endfunction

    function automatic bit close_line(output cue_times_t r);
        r = '0;
        if (err == ST_OK)
        begin
            if (ph == P_LEAD)
            begin
                clear_parser();
                return 1'b0;
            end
            if (ph == P_END + S_M)
            begin
                if (close_ms())
                    ph = P_TAIL;
            end
            else if (ph != P_TAIL)
                flag_error(ST_SYNTAX);
        end
        r.code = err;
        if (err == ST_OK)
        begin
            r.start_t = start_acc;
            r.stop_t = stamp_ms();
            r.letters = letters;
            if (r.start_t > r.stop_t)
                r.code = ST_ORDER;
        end
        clear_parser();
        return 1'b1;
    endfunction

    function automatic bit parse_byte(logic [7:0] c, logic last, output cue_times_t r);
        r = '0;
        if (c == CH_LF || c == CH_CR)
            return close_line(r);
        feed_char(c);
        if (last)
            return close_line(r);
        return 1'b0;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void log_mismatch(string what, longint unsigned want,
                                         longint unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        int         gap;
        cue_times_t r;
        gap = send_idle ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        char_byte <= c;
        line_end <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (parse_byte(c, last, r))
            expected_times.push_back(r);
        sent_chars++;
    endtask

    task automatic hold_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        hold_input();
        while (expected_times.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_line(input chars_t q, input term_e term);
        for (int i = 0; i < q.size(); i++)
            send_char(q[i], term == TERM_FLAG && i == q.size() - 1);
        case (term)
            TERM_LF:
                send_char(CH_LF, 1'($urandom_range(0, 1)));
            TERM_CR:
                send_char(CH_CR, 1'($urandom_range(0, 1)));
            TERM_CRLF:
            begin
                send_char(CH_CR, 1'b0);
                send_char(CH_LF, 1'($urandom_range(0, 1)));
            end
            default:
                ;
        endcase
    endtask

    function automatic void add_text(ref chars_t q, input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endfunction

    task automatic send_text(input string s, input term_e term);
        chars_t q;
        add_text(q, s);
        send_line(q, term);
    endtask

    function automatic void add_blanks(ref chars_t q, input int least);
        int n;
        n = $urandom_range(least, least + 2);
        repeat (n)
            q.push_back($urandom_range(0, 3) == 0 ? CH_TAB : CH_SPACE);
    endfunction

    function automatic string rand_stamp();
        int    h;
        int    m;
        int    s;
        int    ms;
        int    r;
        string hf;
        r = $urandom_range(0, 99);
        m = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
        s = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
        ms = $urandom_range(0, 999);
        if (r < 45)
            return $sformatf("%02d:%02d.%03d", m, s, ms);
        hf = "%0d";
        if (r < 80)
        begin
            h = $urandom_range(0, 99);
            hf = "%02d";
        end
        else if (r < 90)
            h = $urandom_range(0, 9);
        else if (r < 97)
            h = $urandom_range(100, 9999);
        else
            h = $urandom_range(10000, 99999999);
        return {$sformatf(hf, h), $sformatf(":%02d:%02d.%03d", m, s, ms)};
    endfunction

    function automatic void add_tail(ref chars_t q);
        int r;
        int n;
        r = $urandom_range(0, 2);
        if (r == 0)
            return;
        if (r == 1)
            add_blanks(q, 1);
        n = $urandom_range(1, 12);
        repeat (n)
            q.push_back($urandom_range(0, 7) == 0 ? 8'($urandom_range(128, 255))
                                                  : 8'($urandom_range(33, 126)));
    endfunction

    function automatic void build_cue_line(ref chars_t q);
        add_blanks(q, 0);
        add_text(q, rand_stamp());
        add_blanks(q, 1);
        add_text(q, "-->");
        add_blanks(q, 1);
        add_text(q, rand_stamp());
        add_tail(q);
    endfunction

    function automatic logic [7:0] pick_symbol();
        string syms;
        syms = ":.-> 0123456789\t";
        return syms[$urandom_range(0, syms.len() - 1)];
    endfunction

    function automatic void damage_line(ref chars_t q);
        int i;
        int op;
        i = $urandom_range(0, q.size() - 1);
        op = $urandom_range(0, 2);
        if (op == 0)
            q[i] = 8'($urandom_range(0, 255));
        else if (op == 1)
            q.delete(i);
        else
            q.insert(i, pick_symbol());
    endfunction

    function automatic term_e pick_term();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return TERM_LF;
        if (r < 60)
            return TERM_CRLF;
        if (r < 75)
            return TERM_CR;
        return TERM_FLAG;
    endfunction

    task automatic test_valid_lines();
        send_text("00:00.000 --> 00:00.000", TERM_LF);
        send_text("\t 01:02:03.004 \t-->  01:02:03.005 align:start line:0", TERM_CRLF);
        send_text("9999:59:59.999 --> 9999:59:59.999 X", TERM_FLAG);
        send_text("59:59.999 --> 60:00:00.000 123", TERM_CR);
        send_text("00:00.000 --> 00:01.000a", TERM_LF);
    endtask

    task automatic test_hours_fields();
        send_text("5:00:00.000 --> 00:00:01.000", TERM_LF);
        send_text("12345:00:00.000 --> 00:00:01.000", TERM_LF);
        send_text("123456789012345678:00:00.000 --> 0:0", TERM_LF);
        send_text("100:00.000 --> 100:00:00.000", TERM_LF);
        send_text("00:00:60.000 --> 01:00:00.000", TERM_LF);
    endtask

    task automatic test_error_codes();
        chars_t q;
        send_text("00:60.000 --> 01:00.000", TERM_LF);
        send_text("00:00.00 --> 00:01.000", TERM_LF);
        send_text("00:00.000--> 00:01.000", TERM_LF);
        send_text("00:00.000 -->00:01.000", TERM_LF);
        send_text("00:10.000 --> 00:05.000", TERM_LF);
        send_text("00:00.000 --> 00:01.0000000000000000000", TERM_LF);
        send_text("00:00.000 --", TERM_LF);
        send_text("00:00.000 --> 00:01.0", TERM_FLAG);
        q.push_back(8'hFF);
        q.push_back(8'h00);
        send_line(q, TERM_LF);
    endtask

    task automatic test_line_endings();
        chars_t q;
        send_text("", TERM_LF);
        send_text("  \t", TERM_CR);
        send_text("   ", TERM_FLAG);
        add_text(q, "00:00.000 --> 00:01.000 tail");
        q.push_back(8'hFF);
        send_line(q, TERM_FLAG);
        send_text("00:00.000 --> 00:01.000", TERM_FLAG);
        send_char(CH_LF, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_lines();
        chars_t q;
        int     lines;
        int     r;
        int     mode;
        int     n;
        lines = 0;
        while (sent_chars < RANDOM_CHARS)
        begin
            if (lines % 12 == 0)
            begin
                mode = $urandom_range(0, 3);
                send_idle = mode[0];
                take_idle = mode[1];
            end
            if (lines % 20 == 19)
                wait_drained();
            q.delete();
            r = $urandom_range(0, 99);
            if (r < 70)
                build_cue_line(q);
            else if (r < 88)
            begin
                build_cue_line(q);
                repeat ($urandom_range(1, 2))
                    damage_line(q);
            end
            else
            begin
                n = $urandom_range(1, 30);
                repeat (n)
                    q.push_back($urandom_range(0, 2) == 0 ? 8'($urandom_range(0, 255))
                                                          : pick_symbol());
            end
            send_line(q, pick_term());
            lines++;
        end
    endtask

    initial
    begin : take_results
        int n;
        out_ready = 1'b0;
        forever
        begin
            n = take_idle ? pick_gap() : 0;
            @(negedge clk);
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(0, 12)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        cue_times_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_times.size() == 0)
                log_mismatch("unexpected result, status", 0, status);
            else
            begin
                want = expected_times.pop_front();
                if (start_ms !== want.start_t)
                    log_mismatch("start_ms", want.start_t, start_ms);
                if (end_ms !== want.stop_t)
                    log_mismatch("end_ms", want.stop_t, end_ms);
                if (status !== want.code)
                    log_mismatch("status", want.code, status);
                if (settings_present !== want.letters)
                    log_mismatch("settings_present", want.letters, settings_present);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        char_byte = '0;
        line_end = 1'b0;
        clear_parser();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_valid_lines();
        test_hours_fields();
        test_error_codes();
        test_line_endings();
        send_idle = 1'b1;
        take_idle = 1'b1;
        test_random_lines();
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ctlp_pkg.sv
hw/rtl/ctlp_scan.sv
hw/rtl/ctlp_time.sv
hw/rtl/cue_timing_line_parser.sv
dv/cue_timing_line_parser_tb.sv
